/* hdl/bir_pkg.sv */
// Shared types and codes for the bicubic image resampler.
// No dependencies; every other file imports this package.
package bir_pkg;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_X_STEP      = 3'd2;
  localparam logic [2:0] REG_Y_STEP      = 3'd3;
  localparam logic [2:0] REG_SAMPLE_MODE = 3'd4;

  localparam int SIZE_W = 13;

  typedef logic [5:0]        coord_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [20:0]       step_t;
  typedef logic [SIZE_W-1:0] size_t;

  // request to one axis weight unit
  typedef struct packed {
    logic   start;
    coord_t dst;
    step_t  step;
    size_t  size;
  } axis_req_t;

endpackage

/* hdl/bicubic_image_resampler_top.sv */
// Bicubic image resampler. A load word (tuser 0) writes one source sample into the
// frame store. A compute word (tuser 1) returns one interpolated pixel: two axis
// units work out the position and Keys weights, then sixteen taps stream through
// the single read port of the frame store and a six-stage multiply/accumulate
// tail finishes the result. One item is in flight at a time; a finished pixel
// waits in the output register while loads keep flowing in. The store holds no
// reset value: compute only over samples that were loaded. Sizes below 4 or above
// the store are clamped.
// Depends on bir_pkg, bir_axis and bir_filt.
module bicubic_image_resampler_top import bir_pkg::*; #(
  parameter int MAX_WIDTH        = 64,
  parameter int MAX_HEIGHT       = 64,
  parameter int WEIGHT_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coord_x[5:0], coord_y[11:6], sample_value[27:12], zero
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_value[15:0], pixel_x[21:16], pixel_y[27:22], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int WF = WEIGHT_FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AXIS = 2'd1;
  localparam logic [1:0] ST_TAPS = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]  state_r;
  logic [6:0]  width_r, height_r;
  step_t       xstep_r, ystep_r;
  logic        mode_r;
  coord_t      cx_r, cy_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic   in_acc, wr_en, out_load, x_done, y_done, f_done;
  coord_t in_x, in_y;
  size_t  size_w, size_h, bx, by;
  axis_req_t req_x, req_y;
  logic [3:0][WF+2:0] wx, wy;
  sample_t f_result;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_x      = in_tdata[5:0];
  assign in_y      = in_tdata[11:6];
  assign wr_en     = in_acc && (in_tuser == ACT_LOAD)
                     && (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);

  assign size_w = (width_r < 7'd4) ? size_t'(4)
                : (32'(width_r) > MAX_WIDTH) ? size_t'(MAX_WIDTH) : size_t'(width_r);
  assign size_h = (height_r < 7'd4) ? size_t'(4)
                : (32'(height_r) > MAX_HEIGHT) ? size_t'(MAX_HEIGHT) : size_t'(height_r);

  // the axis units read the coordinate in their position state, after the start has passed, so feed the held copy
  assign req_x = '{start: in_acc && (in_tuser == ACT_COMPUTE), dst: cx_r,
                   step: xstep_r, size: size_w};
  assign req_y = '{start: in_acc && (in_tuser == ACT_COMPUTE), dst: cy_r,
                   step: ystep_r, size: size_h};

  bir_axis #(.WF(WF)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .req(req_x), .done(x_done), .base(bx), .wt(wx)
  );

  bir_axis #(.WF(WF)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .req(req_y), .done(y_done), .base(by), .wt(wy)
  );

  bir_filt #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WF(WF)) u_filt (
    .clk(clk), .rst_n(rst_n),
    .wr_en(wr_en), .wr_x(in_x), .wr_y(in_y), .wr_data(in_tdata[27:12]),
    .start(x_done && y_done), .mode(mode_r), .bx(bx), .by(by), .wx(wx), .wy(wy),
    .done(f_done), .result(f_result)
  );

  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= 7'd64;
      height_r    <= 7'd64;
      xstep_r     <= 21'd65536;
      ystep_r     <= 21'd65536;
      mode_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SRC_WIDTH:   width_r  <= cfg_data[6:0];
          REG_SRC_HEIGHT:  height_r <= cfg_data[6:0];
          REG_X_STEP:      xstep_r  <= cfg_data;
          REG_Y_STEP:      ystep_r  <= cfg_data;
          REG_SAMPLE_MODE: mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (req_x.start) state_r <= ST_AXIS;
        ST_AXIS: if (x_done) state_r <= ST_TAPS;
        ST_TAPS: if (f_done) state_r <= ST_HOLD;
        ST_HOLD: if (out_load) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_x.start) begin
      cx_r <= in_x;
      cy_r <= in_y;
    end
    if (out_load) out_data_r <= {4'd0, cy_r, cx_r, f_result};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/bir_axis.sv */
// Axis unit: source position, cubic-convolution weights and edge folding.
// Depends on bir_pkg; one shared multiplier steps through the cubic terms.
module bir_axis import bir_pkg::*; #(
  parameter int WF = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  axis_req_t            req,
  output logic                 done,
  output size_t                base,
  output logic [3:0][WF+2:0]   wt
);

  localparam int W  = WF + 3;
  localparam int SH = 50 - WF;
  localparam int CW = 56;
  localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
  localparam logic signed [CW-1:0] ONE50 = CW'(1) <<< 50;
  localparam logic signed [W-1:0]  ONE  = W'(1) <<< WF;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_POS   = 4'd1;
  localparam logic [3:0] ST_SPLIT = 4'd2;
  localparam logic [3:0] ST_T2    = 4'd3;
  localparam logic [3:0] ST_T3    = 4'd4;
  localparam logic [3:0] ST_U2    = 4'd5;
  localparam logic [3:0] ST_U3    = 4'd6;
  localparam logic [3:0] ST_W0    = 4'd7;
  localparam logic [3:0] ST_W1    = 4'd8;
  localparam logic [3:0] ST_W2    = 4'd9;
  localparam logic [3:0] ST_FOLD  = 4'd10;

  logic [3:0]  state_r;
  logic [32:0] mul_a;
  logic [20:0] mul_b;
  logic [53:0] mul_p;

  logic [27:0]          p_r;
  logic signed [13:0]   sx_r;
  logic [15:0]          t_r;
  logic [16:0]          u_r;
  logic [31:0]          t2_r;
  logic [47:0]          t3_r;
  logic [32:0]          u2_r;
  logic [48:0]          u3_r;
  logic signed [W-1:0]  a0_r, a1_r, a2_r;
  logic                 done_r;
  size_t                base_r;
  logic [3:0][W-1:0]    wt_r;

  logic signed [28:0]   num;
  logic signed [28:0]   pos;
  logic signed [CW-1:0] c0, c1, c2, inner;
  logic signed [13:0]   b_f;
  logic signed [13:0]   sz;
  logic signed [W-1:0]  f0, f1, f2, f3;

  function automatic logic signed [W-1:0] rnd(input logic signed [CW-1:0] c);
    logic signed [CW-1:0] s;
    s = (c + HALF) >>> SH;
    return s[W-1:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_POS: begin
        mul_a = {26'd0, req.dst, 1'b1};
        mul_b = req.step;
      end
      ST_T2: begin
        mul_a = {17'd0, t_r};
        mul_b = {5'd0, t_r};
      end
      ST_T3: begin
        mul_a = {1'b0, t2_r};
        mul_b = {5'd0, t_r};
      end
      ST_U2: begin
        mul_a = {16'd0, u_r};
        mul_b = {4'd0, u_r};
      end
      ST_U3: begin
        mul_a = u2_r;
        mul_b = {4'd0, u_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 54'(mul_a) * 54'(mul_b);
  end

  always_comb begin
    num = $signed({1'b0, p_r}) - 29'sd65536;
    pos = num >>> 1;
    inner = $signed(CW'(t3_r)) - $signed(CW'({t2_r, 17'd0}))
          + $signed(CW'({t_r, 32'd0}));
    c0 = -(inner + (inner <<< 1));
    c1 = $signed(CW'({t3_r, 2'd0})) + $signed(CW'(t3_r))
       - $signed(CW'({t2_r, 19'd0})) - $signed(CW'({t2_r, 16'd0})) + ONE50;
    c2 = $signed(CW'({u3_r, 2'd0})) + $signed(CW'(u3_r))
       - $signed(CW'({u2_r, 19'd0})) - $signed(CW'({u2_r, 16'd0})) + ONE50;
  end

  // fold the outer taps back inside the plane
  always_comb begin
    sz  = $signed({1'b0, req.size});
    b_f = sx_r;
    f0  = a0_r;
    f1  = a1_r;
    f2  = a2_r;
    f3  = ONE - a0_r - a1_r - a2_r;
    if (b_f <= -14'sd1) begin
      b_f = 14'sd1; f0 = ONE - f3; f1 = f3; f2 = '0; f3 = '0;
    end
    if (b_f == 14'sd0) begin
      b_f = 14'sd1; f0 = f0 + f1; f1 = f2; f2 = f3; f3 = '0;
    end
    if (b_f == sz - 14'sd2) begin
      b_f = sz - 14'sd3; f3 = f2 + f3; f2 = f1; f1 = f0; f0 = '0;
    end
    if (b_f >= sz - 14'sd1) begin
      b_f = sz - 14'sd3; f3 = ONE - f0; f2 = f0; f1 = '0; f0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE:  if (req.start) state_r <= ST_POS;
        ST_POS:   state_r <= ST_SPLIT;
        ST_SPLIT: state_r <= ST_T2;
        ST_T2:    state_r <= ST_T3;
        ST_T3:    state_r <= ST_U2;
        ST_U2:    state_r <= ST_U3;
        ST_U3:    state_r <= ST_W0;
        ST_W0:    state_r <= ST_W1;
        ST_W1:    state_r <= ST_W2;
        ST_W2:    state_r <= ST_FOLD;
        ST_FOLD: begin
          state_r <= ST_IDLE;
          done_r  <= 1'b1;
        end
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_POS:   p_r <= mul_p[27:0];
      ST_SPLIT: begin
        sx_r <= {pos[28], pos[28:16]};
        t_r  <= pos[15:0];
        u_r  <= 17'd65536 - {1'b0, pos[15:0]};
      end
      ST_T2:    t2_r <= mul_p[31:0];
      ST_T3:    t3_r <= mul_p[47:0];
      ST_U2:    u2_r <= mul_p[32:0];
      ST_U3:    u3_r <= mul_p[48:0];
      ST_W0:    a0_r <= rnd(c0);
      ST_W1:    a1_r <= rnd(c1);
      ST_W2:    a2_r <= rnd(c2);
      ST_FOLD: begin
        base_r <= b_f[SIZE_W-1:0];
        wt_r   <= {f3, f2, f1, f0};
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign base = base_r;
  assign wt   = wt_r;

endmodule

/* hdl/bir_filt.sv */
// Frame store and 4x4 tap pipeline: horizontal pass per row, then vertical pass.
// Depends on bir_pkg; the store has one write and one registered read port.
module bir_filt import bir_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int WF         = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  coord_t             wr_x,
  input  coord_t             wr_y,
  input  sample_t            wr_data,
  input  logic               start,
  input  logic               mode,
  input  size_t              bx,
  input  size_t              by,
  input  logic [3:0][WF+2:0] wx,
  input  logic [3:0][WF+2:0] wy,
  output logic               done,
  output sample_t            result
);

  localparam int W     = WF + 3;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 16 + W;
  localparam int ACCW  = PW + 2;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;
  logic [AW-1:0] wr_addr, rd_addr;
  size_t row, col;

  logic       run_r;
  logic [3:0] k_r;
  logic       v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, done_r;
  logic [3:0] tag1_r, tag2_r, tag5_r;
  logic [1:0] tag3_r, tag4_r;

  sample_t                smp;
  logic signed [PW-1:0]   prod_r, vprod_r;
  logic signed [ACCW-1:0] hacc_r, vacc_r;
  sample_t                hsat_r, result_r;

  function automatic logic signed [ACCW-1:0] trunc_q(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] bias;
    bias = v[ACCW-1] ? ACCW'((1 << WF) - 1) : '0;
    return (v + bias) >>> WF;
  endfunction

  function automatic sample_t sat(input logic signed [ACCW-1:0] v, input logic m);
    logic signed [ACCW-1:0] hi, lo;
    hi = m ? ACCW'(32767) : ACCW'(127);
    lo = -hi - ACCW'(1);
    if (v > hi) return hi[15:0];
    if (v < lo) return lo[15:0];
    return v[15:0];
  endfunction

  assign wr_addr = AW'(32'(wr_y) * MAX_WIDTH + 32'(wr_x));
  assign row     = by + size_t'(k_r[3:2]) - size_t'(1);
  assign col     = bx + size_t'(k_r[1:0]) - size_t'(1);
  assign rd_addr = AW'(32'(row) * MAX_WIDTH + 32'(col));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign smp = mode ? $signed(rd_data_r) : $signed({{8{rd_data_r[7]}}, rd_data_r[7:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      k_r    <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r <= 1'b1;
        k_r   <= '0;
      end else if (run_r) begin
        k_r <= k_r + 4'd1;
        if (k_r == 4'd15) run_r <= 1'b0;
      end
      v1_r   <= run_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r && (tag2_r[1:0] == 2'd3);
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      v6_r   <= v5_r && (tag5_r[3:2] == 2'd3);
      done_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= k_r;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r[3:2];
    tag4_r <= tag3_r;
    tag5_r <= {tag4_r, 2'd0};
    if (v1_r) prod_r <= smp * $signed(wx[tag1_r[1:0]]);
    // restart the row sum on the first tap of each row
    if (v2_r) hacc_r <= ((tag2_r[1:0] == 2'd0) ? '0 : hacc_r) + ACCW'(prod_r);
    if (v3_r) hsat_r <= sat(trunc_q(hacc_r), mode);
    if (v4_r) vprod_r <= hsat_r * $signed(wy[tag4_r]);
    if (v5_r) vacc_r <= ((tag5_r[3:2] == 2'd0) ? '0 : vacc_r) + ACCW'(vprod_r);
    if (v6_r) result_r <= sat(trunc_q(vacc_r), mode);
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

/* hdl/bir_check.sv */
// Port-level checker for the bicubic image resampler, bound to the top level.
// Depends on bir_pkg for the action codes.
module bir_check import bir_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_COMPUTE) |=> !in_tready)
    else $error("input taken during a compute");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result word");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:28] == 4'd0))
    else $error("result pad bits set");

endmodule

bind bicubic_image_resampler_top bir_check u_bir_check (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
